/* rtl/cfstq_pkg.sv */
// Shared types and constants for the CAN frame segmenting transmit queue.
// Used by cfstq_ctrl, cfstq_dp and can_frame_segmenting_tx_queue_top.
package cfstq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int MAX_MAILBOXES_DEF = 3;
    localparam int FRAME_BYTES       = 8;
    localparam int ID_W              = 29;
    localparam int LEN_W             = 4;
    localparam int CNT_W             = 3;   // pending byte count, 0..7
    localparam int PAYLOAD_W         = 8 * FRAME_BYTES;

    // Input word: one message byte plus its framing information
    typedef struct packed {
        logic            has_byte;
        logic [7:0]      data_byte;
        logic [ID_W-1:0] ext_id;
        logic            end_of_message;
        logic [1:0]      free_mailboxes;
    } msg_word_t;

    // Output word: one drained frame
    typedef struct packed {
        logic [ID_W-1:0]  frame_id;
        logic [LEN_W-1:0] frame_len;
        logic [7:0]       byte0;
        logic [7:0]       byte1;
        logic [7:0]       byte2;
        logic [7:0]       byte3;
        logic [7:0]       byte4;
        logic [7:0]       byte5;
        logic [7:0]       byte6;
        logic [7:0]       byte7;
        logic             last_frame;
    } frm_word_t;

    // One ring entry
    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
    } ring_entry_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic pop;      // read oldest entry, advance read index
        logic load;     // move read data into output register
        logic last;     // frame being loaded ends the drain
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic empty;     // ring holds no frame
        logic one_left;  // ring would be empty after one pop
        logic out_free;  // output register can take a frame this cycle
    } dp_sts_t;

endpackage

/* rtl/cfstq_ctrl.sv */
// Controller FSM for the transmit queue: input handshake and drain sequencing.
// Depends on cfstq_pkg; drives cfstq_dp through dp_cmd_t / dp_sts_t.
module cfstq_ctrl
    import cfstq_pkg::*;
#(
    parameter int MAX_MAILBOXES = MAX_MAILBOXES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    msg_valid,
    output logic    msg_ready,
    input  logic    end_of_message,
    input  logic [1:0] free_mailboxes,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    localparam int LEFT_W = (MAX_MAILBOXES > 1) ? $clog2(MAX_MAILBOXES + 1) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic              last_reg, last_next;
    logic [LEFT_W-1:0] left_init;

    // clamp mailbox count to what the block supports
    always_comb
    begin
        if (32'(free_mailboxes) > MAX_MAILBOXES)
            left_init = LEFT_W'(MAX_MAILBOXES);
        else
            left_init = LEFT_W'(free_mailboxes);
    end

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        last_next  = last_reg;
        msg_ready  = (state_reg == ST_IDLE);
        cmd        = '0;
        cmd.accept = msg_valid && msg_ready;
        cmd.last   = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && end_of_message)
                begin
                    left_next  = left_init;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (left_reg == '0 || sts.empty)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.pop    = 1'b1;
                    last_next  = (left_reg == LEFT_W'(1)) || sts.one_left;
                    left_next  = left_reg - LEFT_W'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = last_reg ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            left_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            last_reg  <= last_next;
        end
    end

    ap_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !sts.empty)
        else $error("pop issued on empty ring");

    ap_pop_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> state_reg == ST_LOAD)
        else $error("pop not followed by load state");

    ap_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(left_reg) <= MAX_MAILBOXES)
        else $error("drain count exceeds mailbox limit");

    ap_no_accept_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.accept)
        else $error("word accepted during drain");

endmodule

/* rtl/cfstq_dp.sv */
// Datapath for the transmit queue: byte packing, frame ring memory, indices,
// output register. Depends on cfstq_pkg; commanded by cfstq_ctrl.
module cfstq_dp
    import cfstq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  msg_word_t msg,
    output logic      frm_valid,
    input  logic      frm_ready,
    output frm_word_t frm,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    ring_entry_t ring_mem [QUEUE_DEPTH];
    ring_entry_t rd_data_reg;

    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     wr_idx_reg, wr_idx_next;
    logic                 full_reg, full_next;
    logic [PAYLOAD_W-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    frm_word_t            out_reg, out_next;

    logic [PAYLOAD_W-1:0] merged;
    logic                 push;
    ring_entry_t          wr_entry;

    // bytes above the count are zero, so OR-in is enough
    always_comb
    begin
        if (msg.has_byte)
            merged = pend_reg | (PAYLOAD_W'(msg.data_byte) << {cnt_reg, 3'b000});
        else
            merged = pend_reg;
        push = cmd.accept &&
               ((msg.has_byte && cnt_reg == CNT_W'(FRAME_BYTES - 1)) ||
                (msg.end_of_message && (msg.has_byte || cnt_reg != '0)));
        wr_entry.id      = msg.ext_id;
        wr_entry.len     = LEN_W'(cnt_reg) + LEN_W'(msg.has_byte);
        wr_entry.payload = merged;
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        full_next   = full_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            pend_next   = '0;
            cnt_next    = '0;
            wr_idx_next = next_idx(wr_idx_reg);
            if (full_reg)
                rd_idx_next = next_idx(rd_idx_reg);
            full_next = (next_idx(wr_idx_reg) == rd_idx_next);
        end
        else if (cmd.accept && msg.has_byte)
        begin
            pend_next = merged;
            cnt_next  = cnt_reg + CNT_W'(1);
        end
        if (cmd.pop)
        begin
            rd_idx_next = next_idx(rd_idx_reg);
            full_next   = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (cmd.load)
        begin
            out_valid_next      = 1'b1;
            out_next.frame_id   = rd_data_reg.id;
            out_next.frame_len  = rd_data_reg.len;
            out_next.byte0      = rd_data_reg.payload[7:0];
            out_next.byte1      = rd_data_reg.payload[15:8];
            out_next.byte2      = rd_data_reg.payload[23:16];
            out_next.byte3      = rd_data_reg.payload[31:24];
            out_next.byte4      = rd_data_reg.payload[39:32];
            out_next.byte5      = rd_data_reg.payload[47:40];
            out_next.byte6      = rd_data_reg.payload[55:48];
            out_next.byte7      = rd_data_reg.payload[63:56];
            out_next.last_frame = cmd.last;
        end
        else if (frm_ready)
            out_valid_next = 1'b0;
    end

    // frame memory, no reset: entries are written before they are read
    always_ff @(posedge clk)
    begin
        if (push)
            ring_mem[wr_idx_reg] <= wr_entry;
        if (cmd.pop)
            rd_data_reg <= ring_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            full_reg      <= 1'b0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            full_reg      <= full_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign sts.empty    = !full_reg && (rd_idx_reg == wr_idx_reg);
    assign sts.one_left = (next_idx(rd_idx_reg) == wr_idx_reg);
    assign sts.out_free = !out_valid_reg || frm_ready;

    assign frm_valid = out_valid_reg;
    assign frm       = out_reg;

    ap_full_idx_equal: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> rd_idx_reg == wr_idx_reg)
        else $error("ring full with unequal indices");

    ap_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || frm_ready))
        else $error("output overwritten before it was taken");

endmodule

/* rtl/can_frame_segmenting_tx_queue_top.sv */
// CAN frame segmenting transmit queue, top level.
// Channels: msg (input words, one message byte each) and frm (drained frames),
// both valid/ready; an item moves when valid and ready are high at a clock edge.
// A word without end_of_message leaves msg_ready high; bytes are packed into 8-byte
// frames, and a full frame is written into a QUEUE_DEPTH-entry ring memory in
// the cycle its last byte is taken. A full ring drops its oldest frame.
// A word with end_of_message closes any partial frame, then drains up to
// min(free_mailboxes, MAX_MAILBOXES) frames, oldest first: the ring memory has
// one registered read port, so each frame takes a read state (ST_READ) and then
// a load state (ST_LOAD). msg_ready stays low during the drain.
// The frame output register is separate from the drain logic, so byte words are
// taken while a frame waits; a stalled receiver holds up the next load, and with
// it the end of the drain.
// last_frame marks the final frame of a drain.
// Reset (rst_n, async, active low) empties the ring and the pending frame; the
// ring memory itself is not cleared and no clearing pass is needed.
module can_frame_segmenting_tx_queue_top
    import cfstq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int MAX_MAILBOXES = MAX_MAILBOXES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      msg_valid,
    output logic      msg_ready,
    input  msg_word_t msg,
    output logic      frm_valid,
    input  logic      frm_ready,
    output frm_word_t frm
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    cfstq_ctrl #(
        .MAX_MAILBOXES (MAX_MAILBOXES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_ready      (msg_ready),
        .end_of_message (msg.end_of_message),
        .free_mailboxes (msg.free_mailboxes),
        .cmd            (cmd),
        .sts            (sts)
    );

    cfstq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
